FILE: rtl/core/ebp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_pkg
// Shared types and constants of the element bounds propagator.
// ----------------------------------------------------------------------------
package ebp_pkg;

  localparam int unsigned MAX_ELEM = 1024;
  localparam int unsigned IW       = $clog2(MAX_ELEM);   // element index bits
  localparam int unsigned CW       = IW + 1;             // element count bits
  localparam int unsigned SW       = CW + 1;             // signed search bound bits
  localparam int unsigned LEVELS   = 11;
  localparam int unsigned LW       = $clog2(LEVELS);
  localparam int unsigned SP_DEPTH = LEVELS * MAX_ELEM;
  localparam int unsigned SPW      = LW + IW;
  localparam int unsigned VW       = 32;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned CFG_IW   = 2;

  localparam logic [CFG_IW-1:0] REG_FROM_ZERO = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COUNT     = 2'd1;

  typedef enum logic [2:0] {
    MODE_LOAD  = 3'd0,
    MODE_BUILD = 3'd1,
    MODE_RANGE = 3'd2,
    MODE_RAISE = 3'd3,
    MODE_LOWER = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PRE,
    BK_SUF,
    BK_SPR,
    BK_SETUP,
    BK_RRD,
    BK_RCMP,
    BK_SRD,
    BK_SCMP,
    BK_PRD,
    BK_PCMP,
    BK_CHK,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    mode_e                 op;
    logic [IW-1:0]         addr;
    logic signed [VW-1:0]  value;
    logic signed [VW-1:0]  idx_lo;
    logic signed [VW-1:0]  idx_hi;
    logic signed [VW-1:0]  res_lo;
    logic signed [VW-1:0]  res_hi;
  } q_item_t;

  // largest k with 2^k <= len, capped at the top table level
  function automatic logic [LW-1:0] floor_log2(input logic [CW-1:0] len);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 1; i < LEVELS; i++) begin
      if (len >= (CW'(1) << i)) begin
        r = LW'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/element_bounds_propagator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// element_bounds_propagator
// Bounds propagation for result = A[index] over range tables in block memory.
// ----------------------------------------------------------------------------
// A load item writes one element as the back end takes it. A build item
// sweeps the element memory twice (prefix and suffix tables) and then each
// sparse level k >= 1 once, each table written through its single write
// port. An index-to-result query steps through setup, one paired range read,
// compare and result. A raised minimum or lowered maximum takes two binary
// searches, each step a memory read and a compare. A two-entry queue sits
// in front of the engine and the result is registered, so items are taken
// while a result waits. Table contents are undefined until a build; there
// is no clearing pass after reset.
module element_bounds_propagator import ebp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IW-1:0]    cfg_index_i,
  input  logic [COUNT_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic [IW-1:0]        elem_addr_i,
  input  logic signed [VW-1:0] elem_value_i,
  input  logic signed [VW-1:0] idx_lo_i,
  input  logic signed [VW-1:0] idx_hi_i,
  input  logic signed [VW-1:0] res_lo_i,
  input  logic signed [VW-1:0] res_hi_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 fail_o,
  output logic signed [VW-1:0] new_lo_o,
  output logic signed [VW-1:0] new_hi_o,
  output logic                 lo_tightened_o,
  output logic                 hi_tightened_o
);

  logic               from_zero_q;
  logic [COUNT_W-1:0] count_q;
  logic [CW-1:0]      n_active;
  logic               item_valid, item_pop;
  q_item_t            item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_zero_q <= 1'b1;
      count_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FROM_ZERO: from_zero_q <= cfg_data_i[0];
        REG_COUNT:     count_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // count saturates at the table depth
  assign n_active = (32'(count_q) > MAX_ELEM) ? CW'(MAX_ELEM) : CW'(count_q);

  ebp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .elem_addr_i  (elem_addr_i),
    .elem_value_i (elem_value_i),
    .idx_lo_i     (idx_lo_i),
    .idx_hi_i     (idx_hi_i),
    .res_lo_i     (res_lo_i),
    .res_hi_i     (res_hi_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  ebp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_pop_o     (item_pop),
    .n_i            (n_active),
    .from_zero_i    (from_zero_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fail_o         (fail_o),
    .new_lo_o       (new_lo_o),
    .new_hi_o       (new_hi_o),
    .lo_tightened_o (lo_tightened_o),
    .hi_tightened_o (hi_tightened_o)
  );

endmodule

FILE: rtl/core/ebp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_front
// Accepts input items, drops unused modes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module ebp_front import ebp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           mode_i,
  input  logic [IW-1:0]        elem_addr_i,
  input  logic signed [VW-1:0] elem_value_i,
  input  logic signed [VW-1:0] idx_lo_i,
  input  logic signed [VW-1:0] idx_hi_i,
  input  logic signed [VW-1:0] res_lo_i,
  input  logic signed [VW-1:0] res_hi_i,
  output logic                 item_valid_o,
  output q_item_t              item_o,
  input  logic                 item_pop_i
);

  localparam logic [1:0] QDEPTH = 2'd2;

  q_item_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       known;
  logic       push;
  q_item_t    new_item;

  always_comb begin
    unique case (mode_i)
      MODE_LOAD, MODE_BUILD, MODE_RANGE, MODE_RAISE, MODE_LOWER: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready_o   = (cnt_q != QDEPTH);
  assign push         = in_valid_i && in_ready_o && known;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];

  always_comb begin
    new_item.op     = mode_e'(mode_i);
    new_item.addr   = elem_addr_i;
    new_item.value  = elem_value_i;
    new_item.idx_lo = idx_lo_i;
    new_item.idx_hi = idx_hi_i;
    new_item.res_lo = res_lo_i;
    new_item.res_hi = res_hi_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(item_pop_i && item_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && item_pop_i && item_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (item_pop_i && item_valid_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

FILE: rtl/core/ebp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_back
// Table memories, build sequencer and query engine with a result register.
// ----------------------------------------------------------------------------
module ebp_back import ebp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  q_item_t              item_i,
  output logic                 item_pop_o,
  input  logic [CW-1:0]        n_i,
  input  logic                 from_zero_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 fail_o,
  output logic signed [VW-1:0] new_lo_o,
  output logic signed [VW-1:0] new_hi_o,
  output logic                 lo_tightened_o,
  output logic                 hi_tightened_o
);

  // memories
  logic signed [VW-1:0] elem_mem  [MAX_ELEM];
  logic signed [VW-1:0] pmin_mem  [MAX_ELEM];
  logic signed [VW-1:0] pmax_mem  [MAX_ELEM];
  logic signed [VW-1:0] smin_mem  [MAX_ELEM];
  logic signed [VW-1:0] smax_mem  [MAX_ELEM];
  logic signed [VW-1:0] spmin_mem [SP_DEPTH];
  logic signed [VW-1:0] spmax_mem [SP_DEPTH];

  logic signed [VW-1:0] elem_rd_q, pmin_rd_q, pmax_rd_q, smin_rd_q, smax_rd_q;
  logic signed [VW-1:0] spmin_a_q, spmin_b_q, spmax_a_q, spmax_b_q;

  bk_state_e state_q, state_d;

  // control
  logic [CW-1:0] bcnt_q;
  logic          wvld_q;
  logic [IW-1:0] widx_q;
  logic [LW-1:0] lvl_q;
  logic          out_valid_q;

  // payload
  q_item_t              it_q;
  logic signed [VW-1:0] acc_min_q, acc_max_q;
  logic [IW-1:0]        lo0_q, hi0_q, mid_q;
  logic signed [SW-1:0] left_q, right_q, cand_hi_q, cand_lo_q;
  logic                 r_fail_q, r_lt_q, r_ht_q;
  logic signed [VW-1:0] r_lo_q, r_hi_q;
  logic                 o_fail_q, o_lt_q, o_ht_q;
  logic signed [VW-1:0] o_lo_q, o_hi_q;

  // memory controls
  logic                 elem_we;
  logic [IW-1:0]        elem_raddr;
  logic                 issue;
  logic [IW-1:0]        issue_idx;
  logic                 pre_we, suf_we, sp_we;
  logic signed [VW-1:0] min_wd, max_wd, spmin_wd, spmax_wd;
  logic [SPW-1:0]       sp_waddr, sp_ra, sp_rb;
  logic [IW-1:0]        pm_raddr;
  logic                 done_ph;
  logic [SW-1:0]        lvl_pow, next_pow;
  logic [CW-1:0]        half;

  // query datapath
  logic signed [VW:0]   off33, lo_s, hi_s, lo_c, hi_c, nm1;
  logic                 setup_fail;
  logic [CW-1:0]        rlen;
  logic [LW-1:0]        rk;
  logic [CW-1:0]        rj;
  logic [SW-1:0]        mid_sum;
  logic [IW-1:0]        mid_c;
  logic                 raise;
  logic signed [VW-1:0] bound;
  logic                 suf_out, pre_out;
  logic signed [VW-1:0] rmin, rmax;
  logic signed [VW:0]   chi, clo, idx_lo33, idx_hi33;
  logic                 ht_c, lt_c, cross_c, clo_fail;
  logic signed [VW-1:0] nlo_c, nhi_c, pass_lo, pass_hi;
  logic                 out_free;

  assign item_pop_o = (state_q == BK_IDLE) && item_valid_i;
  assign out_free   = !out_valid_q || out_ready_i;

  assign lvl_pow  = SW'(1) << lvl_q;
  assign next_pow = SW'(1) << (lvl_q + LW'(1));
  assign half     = CW'(1) << (lvl_q - LW'(1));

  // ---------------------------------------------------------------- datapath
  always_comb begin
    off33    = {{VW{1'b0}}, !from_zero_i};
    lo_s     = {it_q.idx_lo[VW-1], it_q.idx_lo} - off33;
    hi_s     = {it_q.idx_hi[VW-1], it_q.idx_hi} - off33;
    nm1      = {{(VW+1-CW){1'b0}}, n_i} - (VW+1)'(1);
    lo_c     = lo_s[VW] ? '0 : lo_s;
    hi_c     = (hi_s > nm1) ? nm1 : hi_s;
    setup_fail = (n_i == '0) || (lo_c > hi_c);

    rlen = CW'(hi0_q) - CW'(lo0_q) + CW'(1);
    rk   = floor_log2(rlen);
    rj   = CW'(hi0_q) - (CW'(1) << rk) + CW'(1);

    mid_sum = left_q + right_q;
    mid_c   = mid_sum[IW:1];

    raise   = (it_q.op == MODE_RAISE);
    bound   = raise ? it_q.res_lo : it_q.res_hi;
    suf_out = raise ? (smax_rd_q < bound) : (smin_rd_q > bound);
    pre_out = raise ? (pmax_rd_q < bound) : (pmin_rd_q > bound);

    rmin = (spmin_a_q < spmin_b_q) ? spmin_a_q : spmin_b_q;
    rmax = (spmax_a_q > spmax_b_q) ? spmax_a_q : spmax_b_q;

    idx_lo33 = {it_q.idx_lo[VW-1], it_q.idx_lo};
    idx_hi33 = {it_q.idx_hi[VW-1], it_q.idx_hi};
    chi      = {{(VW+1-SW){cand_hi_q[SW-1]}}, cand_hi_q} + off33;
    clo      = {{(VW+1-SW){cand_lo_q[SW-1]}}, cand_lo_q} + off33;
    ht_c     = chi < idx_hi33;
    lt_c     = clo > idx_lo33;
    nhi_c    = ht_c ? chi[VW-1:0] : it_q.idx_hi;
    nlo_c    = lt_c ? clo[VW-1:0] : it_q.idx_lo;
    cross_c  = nlo_c > nhi_c;
    clo_fail = cand_lo_q >= $signed({1'b0, n_i});

    pass_lo = (it_q.op == MODE_RANGE) ? it_q.res_lo : it_q.idx_lo;
    pass_hi = (it_q.op == MODE_RANGE) ? it_q.res_hi : it_q.idx_hi;
  end

  // --------------------------------------------------------- memory controls
  always_comb begin
    elem_we   = item_pop_o && (item_i.op == MODE_LOAD);
    issue     = 1'b0;
    issue_idx = bcnt_q[IW-1:0];
    unique case (state_q)
      BK_PRE: issue = bcnt_q < n_i;
      BK_SUF: begin
        issue     = bcnt_q < n_i;
        issue_idx = IW'(n_i - CW'(1) - bcnt_q);
      end
      BK_SPR: issue = ({1'b0, bcnt_q} + lvl_pow) <= {1'b0, n_i};
      default: issue = 1'b0;
    endcase
    elem_raddr = issue_idx;
    done_ph    = !issue && !wvld_q;

    pre_we = (state_q == BK_PRE) && wvld_q;
    suf_we = (state_q == BK_SUF) && wvld_q;
    if ((state_q == BK_PRE && widx_q == '0) ||
        (state_q == BK_SUF && CW'(widx_q) == n_i - CW'(1))) begin
      min_wd = elem_rd_q;
      max_wd = elem_rd_q;
    end else begin
      min_wd = (elem_rd_q < acc_min_q) ? elem_rd_q : acc_min_q;
      max_wd = (elem_rd_q > acc_max_q) ? elem_rd_q : acc_max_q;
    end

    sp_we = wvld_q && (state_q == BK_PRE || state_q == BK_SPR);
    if (state_q == BK_SPR) begin
      sp_waddr = {lvl_q, widx_q};
      spmin_wd = rmin;
      spmax_wd = rmax;
      sp_ra    = {lvl_q - LW'(1), bcnt_q[IW-1:0]};
      sp_rb    = {lvl_q - LW'(1), IW'(bcnt_q + half)};
    end else begin
      sp_waddr = {LW'(0), widx_q};
      spmin_wd = elem_rd_q;
      spmax_wd = elem_rd_q;
      sp_ra    = {rk, lo0_q};
      sp_rb    = {rk, rj[IW-1:0]};
    end
    pm_raddr = mid_c;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[item_i.addr] <= item_i.value;
    end
    elem_rd_q <= elem_mem[elem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pre_we) begin
      pmin_mem[widx_q] <= min_wd;
      pmax_mem[widx_q] <= max_wd;
    end
    pmin_rd_q <= pmin_mem[pm_raddr];
    pmax_rd_q <= pmax_mem[pm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (suf_we) begin
      smin_mem[widx_q] <= min_wd;
      smax_mem[widx_q] <= max_wd;
    end
    smin_rd_q <= smin_mem[pm_raddr];
    smax_rd_q <= smax_mem[pm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      spmin_mem[sp_waddr] <= spmin_wd;
    end
    spmin_a_q <= spmin_mem[sp_ra];
    spmin_b_q <= spmin_mem[sp_rb];
  end

  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      spmax_mem[sp_waddr] <= spmax_wd;
    end
    spmax_a_q <= spmax_mem[sp_ra];
    spmax_b_q <= spmax_mem[sp_rb];
  end

  // -------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          case (item_i.op)
            MODE_LOAD:  state_d = BK_IDLE;
            MODE_BUILD: state_d = (n_i != '0) ? BK_PRE : BK_IDLE;
            default:    state_d = BK_SETUP;
          endcase
        end
      end
      BK_PRE: if (done_ph) state_d = BK_SUF;
      BK_SUF: if (done_ph) state_d = (n_i >= CW'(2)) ? BK_SPR : BK_IDLE;
      BK_SPR: begin
        if (done_ph && !(32'(lvl_q) + 1 < LEVELS && next_pow <= {1'b0, n_i})) begin
          state_d = BK_IDLE;
        end
      end
      BK_SETUP: begin
        if (setup_fail)                 state_d = BK_OUT;
        else if (it_q.op == MODE_RANGE) state_d = BK_RRD;
        else                            state_d = BK_SRD;
      end
      BK_RRD:  state_d = BK_RCMP;
      BK_RCMP: state_d = BK_OUT;
      BK_SRD:  state_d = (left_q <= right_q) ? BK_SCMP : BK_PRD;
      BK_SCMP: state_d = (suf_out && mid_q == '0) ? BK_OUT : BK_SRD;
      BK_PRD:  state_d = (left_q <= right_q) ? BK_PCMP : BK_CHK;
      BK_PCMP: state_d = BK_PRD;
      BK_CHK:  state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // ------------------------------------------------------------ control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      bcnt_q      <= '0;
      wvld_q      <= 1'b0;
      widx_q      <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wvld_q  <= issue;
      widx_q  <= issue_idx;
      if (state_q == BK_IDLE || done_ph) begin
        bcnt_q <= '0;
      end else if (issue) begin
        bcnt_q <= bcnt_q + CW'(1);
      end
      if (state_q == BK_SUF) begin
        lvl_q <= LW'(1);
      end else if (state_q == BK_SPR && done_ph) begin
        lvl_q <= lvl_q + LW'(1);
      end
      if (state_q == BK_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ payload regs
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      it_q <= item_i;
    end
    if (pre_we || suf_we) begin
      acc_min_q <= min_wd;
      acc_max_q <= max_wd;
    end
    case (state_q)
      BK_SETUP: begin
        lo0_q     <= lo_c[IW-1:0];
        hi0_q     <= hi_c[IW-1:0];
        left_q    <= SW'(lo_c[IW-1:0]);
        right_q   <= SW'(hi_c[IW-1:0]);
        cand_hi_q <= SW'(hi_c[IW-1:0]);
        r_fail_q  <= setup_fail;
        r_lo_q    <= pass_lo;
        r_hi_q    <= pass_hi;
        r_lt_q    <= 1'b0;
        r_ht_q    <= 1'b0;
      end
      BK_RCMP: begin
        r_lt_q <= rmin > it_q.res_lo;
        r_ht_q <= rmax < it_q.res_hi;
        r_lo_q <= (rmin > it_q.res_lo) ? rmin : it_q.res_lo;
        r_hi_q <= (rmax < it_q.res_hi) ? rmax : it_q.res_hi;
      end
      BK_SRD: begin
        mid_q <= mid_c;
        if (left_q > right_q) begin
          // second search starts over the clipped range
          left_q    <= SW'(lo0_q);
          right_q   <= SW'(hi0_q);
          cand_lo_q <= SW'(lo0_q);
        end
      end
      BK_SCMP: begin
        if (suf_out) begin
          if (mid_q == '0) begin
            r_fail_q <= 1'b1;
          end
          cand_hi_q <= SW'(mid_q) - SW'(1);
          right_q   <= SW'(mid_q) - SW'(1);
        end else begin
          left_q <= SW'(mid_q) + SW'(1);
        end
      end
      BK_PRD: mid_q <= mid_c;
      BK_PCMP: begin
        if (pre_out) begin
          cand_lo_q <= SW'(mid_q) + SW'(1);
          left_q    <= SW'(mid_q) + SW'(1);
        end else begin
          right_q <= SW'(mid_q) - SW'(1);
        end
      end
      BK_CHK: begin
        if (clo_fail || cross_c) begin
          r_fail_q <= 1'b1;
        end else begin
          r_lo_q <= nlo_c;
          r_hi_q <= nhi_c;
          r_lt_q <= lt_c;
          r_ht_q <= ht_c;
        end
      end
      default: ;
    endcase
    if (state_q == BK_OUT && out_free) begin
      o_fail_q <= r_fail_q;
      o_lo_q   <= r_lo_q;
      o_hi_q   <= r_hi_q;
      o_lt_q   <= r_lt_q && !r_fail_q;
      o_ht_q   <= r_ht_q && !r_fail_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fail_o         = o_fail_q;
  assign new_lo_o       = o_lo_q;
  assign new_hi_o       = o_hi_q;
  assign lo_tightened_o = o_lt_q;
  assign hi_tightened_o = o_ht_q;

endmodule

FILE: rtl/core/ebp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_checker
// Port-level checks of the element bounds propagator.
// ----------------------------------------------------------------------------
module ebp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        fail_o,
  input logic [31:0] new_lo_o,
  input logic        lo_tightened_o,
  input logic        hi_tightened_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_lo_o))
    else $error("result dropped or changed while stalled");

  a_fail_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fail_o |-> !lo_tightened_o && !hi_tightened_o)
    else $error("failed item reports a tightened bound");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("register port not ready");

endmodule

bind element_bounds_propagator ebp_checker u_ebp_checker (.*);

FILE: test/element_bounds_propagator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// element_bounds_propagator_tb
// Self-checking bench: loads arrays, builds the range tables and runs queries
// of all three kinds against an in-bench bounds predictor, with random gaps
// and stalls on both handshakes and several index base / count settings.
// ----------------------------------------------------------------------------
module element_bounds_propagator_tb;
  import ebp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  // a build over a full array plus queued items, worst case
  localparam int unsigned SETTLE_CYCLES = MAX_ELEM * (2 + LEVELS) + 400;

  typedef struct packed {
    logic                 fail;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic                 lt;
    logic                 ht;
  } bounds_res_t;

  class bounds_scoreboard;
    bounds_res_t pending[$];
    int          errors = 0;

    function void note_query(bounds_res_t r);
      pending.insert(pending.size(), r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(bounds_res_t got);
      bounds_res_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.fail !== want.fail)
        report_mismatch($sformatf("fail got %0d want %0d", got.fail, want.fail));
      if (got.lo !== want.lo)
        report_mismatch($sformatf("new_lo got %0d want %0d", got.lo, want.lo));
      if (got.hi !== want.hi)
        report_mismatch($sformatf("new_hi got %0d want %0d", got.hi, want.hi));
      if (got.lt !== want.lt)
        report_mismatch($sformatf("lo_tightened got %0d want %0d", got.lt, want.lt));
      if (got.ht !== want.ht)
        report_mismatch($sformatf("hi_tightened got %0d want %0d", got.ht, want.ht));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IW-1:0]    cfg_index_i = '0;
  logic [COUNT_W-1:0]   cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [2:0]           mode_i = '0;
  logic [IW-1:0]        elem_addr_i = '0;
  logic signed [VW-1:0] elem_value_i = '0;
  logic signed [VW-1:0] idx_lo_i = '0;
  logic signed [VW-1:0] idx_hi_i = '0;
  logic signed [VW-1:0] res_lo_i = '0;
  logic signed [VW-1:0] res_hi_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 fail_o;
  logic signed [VW-1:0] new_lo_o;
  logic signed [VW-1:0] new_hi_o;
  logic                 lo_tightened_o;
  logic                 hi_tightened_o;

  element_bounds_propagator dut (.*);

  bounds_scoreboard sb = new();
  int unsigned      cycles = 0;
  bit               calm = 1'b0;

  // predictor state
  bit     from_zero = 1'b1;
  int     count_reg = 0;
  longint elems[MAX_ELEM];
  longint pre_min[MAX_ELEM], pre_max[MAX_ELEM];
  longint suf_min[MAX_ELEM], suf_max[MAX_ELEM];
  longint sp_min[LEVELS][MAX_ELEM], sp_max[LEVELS][MAX_ELEM];

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("element_bounds_propagator regression: fail");
      $finish;
    end
  end

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic int live_count();
    return count_reg > MAX_ELEM ? MAX_ELEM : count_reg;
  endfunction

  function automatic void build_range_tables();
    int n;
    n = live_count();
    if (n <= 0) return;
    pre_min[0] = elems[0];
    pre_max[0] = elems[0];
    for (int i = 1; i < n; i++) begin
      pre_min[i] = lmin(pre_min[i-1], elems[i]);
      pre_max[i] = lmax(pre_max[i-1], elems[i]);
    end
    suf_min[n-1] = elems[n-1];
    suf_max[n-1] = elems[n-1];
    for (int i = n - 1; i > 0; i--) begin
      suf_min[i-1] = lmin(suf_min[i], elems[i-1]);
      suf_max[i-1] = lmax(suf_max[i], elems[i-1]);
    end
    for (int i = 0; i < n; i++) begin
      sp_min[0][i] = elems[i];
      sp_max[0][i] = elems[i];
    end
    for (int k = 1; k < LEVELS && (1 << k) <= n; k++) begin
      for (int i = 0; i + (1 << k) <= n; i++) begin
        sp_min[k][i] = lmin(sp_min[k-1][i], sp_min[k-1][i + (1 << (k-1))]);
        sp_max[k][i] = lmax(sp_max[k-1][i], sp_max[k-1][i + (1 << (k-1))]);
      end
    end
  endfunction

  // returns 1 when the item yields a result
  function automatic bit predict_bounds(input logic [2:0] m, input logic [IW-1:0] addr,
                                        input logic signed [VW-1:0] val,
                                        input logic signed [VW-1:0] ilo_v,
                                        input logic signed [VW-1:0] ihi_v,
                                        input logic signed [VW-1:0] rlo_v,
                                        input logic signed [VW-1:0] rhi_v,
                                        output bounds_res_t r);
    longint ilo, ihi, rlo, rhi, n, off, lo0, hi0, nlo, nhi;
    longint left, right, mid, cand_lo, cand_hi, bound, len, j, rmin, rmax;
    bit     fl, lt, ht, raised, out_of;
    int     k;
    ilo = ilo_v; ihi = ihi_v; rlo = rlo_v; rhi = rhi_v;
    n = live_count();
    off = from_zero ? 0 : 1;
    fl = 0; lt = 0; ht = 0;
    r = '0;
    if (m == MODE_LOAD) begin
      elems[addr] = val;
      return 0;
    end
    if (m == MODE_BUILD) begin
      build_range_tables();
      return 0;
    end
    if (m > MODE_LOWER) return 0;
    if (m == MODE_RANGE) begin
      nlo = rlo; nhi = rhi;
    end else begin
      nlo = ilo; nhi = ihi;
    end
    lo0 = lmax(ilo - off, 0);
    hi0 = lmin(ihi - off, n - 1);
    if (n == 0 || lo0 > hi0) begin
      fl = 1;
    end else if (m == MODE_RANGE) begin
      len = hi0 - lo0 + 1;
      k = 0;
      while (k + 1 < LEVELS && (longint'(1) << (k + 1)) <= len) k++;
      j = hi0 - (longint'(1) << k) + 1;
      rmin = lmin(sp_min[k][lo0], sp_min[k][j]);
      rmax = lmax(sp_max[k][lo0], sp_max[k][j]);
      if (rmin > rlo) begin
        nlo = rmin; lt = 1;
      end
      if (rmax < rhi) begin
        nhi = rmax; ht = 1;
      end
    end else begin
      raised = (m == MODE_RAISE);
      bound = raised ? rlo : rhi;
      left = lo0; right = hi0; cand_hi = hi0; cand_lo = lo0;
      while (left <= right) begin
        mid = left + (right - left) / 2;
        out_of = raised ? (suf_max[mid] < bound) : (suf_min[mid] > bound);
        if (out_of) begin
          if (mid == 0) begin
            fl = 1;
            break;
          end
          cand_hi = mid - 1;
          right = mid - 1;
        end else begin
          left = mid + 1;
        end
      end
      if (!fl) begin
        left = lo0; right = hi0;
        while (left <= right) begin
          mid = left + (right - left) / 2;
          out_of = raised ? (pre_max[mid] < bound) : (pre_min[mid] > bound);
          if (out_of) begin
            cand_lo = mid + 1;
            left = mid + 1;
          end else begin
            right = mid - 1;
          end
        end
        if (cand_lo >= n) fl = 1;
      end
      if (!fl) begin
        if (cand_hi + off < ihi) begin
          nhi = cand_hi + off; ht = 1;
        end
        if (cand_lo + off > ilo) begin
          nlo = cand_lo + off; lt = 1;
        end
        if (nlo > nhi) fl = 1;
      end
    end
    if (fl) begin
      lt = 0; ht = 0;
      if (m == MODE_RANGE) begin
        nlo = rlo; nhi = rhi;
      end else begin
        nlo = ilo; nhi = ihi;
      end
    end
    r.fail = fl;
    r.lo = nlo[VW-1:0];
    r.hi = nhi[VW-1:0];
    r.lt = lt;
    r.ht = ht;
    return 1;
  endfunction

  task automatic send_item(input logic [2:0] m, input logic [IW-1:0] addr,
                           input logic signed [VW-1:0] val,
                           input logic signed [VW-1:0] ilo, input logic signed [VW-1:0] ihi,
                           input logic signed [VW-1:0] rlo, input logic signed [VW-1:0] rhi);
    int          gap;
    bounds_res_t r;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    elem_addr_i  <= addr;
    elem_value_i <= val;
    idx_lo_i     <= ilo;
    idx_hi_i     <= ihi;
    res_lo_i     <= rlo;
    res_hi_i     <= rhi;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_bounds(m, addr, val, ilo, ihi, rlo, rhi, r)) sb.note_query(r);
  endtask

  task automatic load_elem(input int addr, input logic signed [VW-1:0] val);
    send_item(MODE_LOAD, IW'(addr), val, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= COUNT_W'(data);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_FROM_ZERO) from_zero = data[0];
    else if (idx == REG_COUNT) count_reg = data & 32'h7ff;
  endtask

  // quiet the input side and let every queued item, builds too, finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 80)) - 40;
    endcase
  endfunction

  function automatic logic signed [VW-1:0] pick_index(int n);
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $urandom;
      default: return $signed($urandom_range(0, n + 6)) - 3;
    endcase
  endfunction

  function automatic logic signed [VW-1:0] pick_result_bound(int n);
    longint v;
    if (n > 0 && $urandom_range(0, 2) != 0) begin
      v = elems[$urandom_range(0, n - 1)] + $signed($urandom_range(0, 4)) - 2;
      return v[VW-1:0];
    end
    return pick_value();
  endfunction

  task automatic random_query(int n);
    logic signed [VW-1:0] ilo, ihi, rlo, rhi;
    logic [2:0] m;
    ilo = pick_index(n);
    ihi = pick_index(n);
    if ($urandom_range(0, 3) != 0 && ilo > ihi) begin
      rlo = ilo; ilo = ihi; ihi = rlo;
    end
    rlo = pick_result_bound(n);
    rhi = pick_result_bound(n);
    m = 3'(MODE_RANGE) + 3'($urandom_range(0, 2));
    send_item(m, IW'($urandom), $urandom, ilo, ihi, rlo, rhi);
  endtask

  // reads stay inside what the last build wrote: loads cover the whole count
  task automatic random_phase(bit zb, int cnt, int queries, bit quiet);
    int n;
    settle();
    calm = quiet;
    write_reg(REG_FROM_ZERO, zb);
    write_reg(REG_COUNT, cnt);
    n = live_count();
    for (int i = 0; i < n; i++) load_elem(i, pick_value());
    send_item(MODE_BUILD, IW'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int q = 0; q < queries; q++) begin
      case ($urandom_range(0, 19))
        0: load_elem($urandom_range(0, MAX_ELEM - 1), pick_value());
        1: send_item(MODE_BUILD, IW'($urandom), $urandom, $urandom, $urandom, $urandom,
                     $urandom);
        2: send_item(3'(MODE_LOWER) + 3'($urandom_range(1, 3)), IW'($urandom), $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        default: random_query(n);
      endcase
    end
  endtask

  task automatic directed_phase();
    settle();
    calm = 1'b1;
    write_reg(REG_FROM_ZERO, 1);
    write_reg(REG_COUNT, 5);
    load_elem(0, 10);
    load_elem(1, 32'sh80000000);
    load_elem(2, 7);
    load_elem(3, 32'sh7fffffff);
    load_elem(4, -3);
    send_item(MODE_BUILD, '0, '0, '0, '0, '0, '0);
    send_item(MODE_RANGE, '0, '0, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff);
    send_item(MODE_RANGE, '0, '0, 0, 2, 0, 5);
    send_item(MODE_RANGE, '0, '0, 3, 1, 0, 5);          // crossed index bounds
    send_item(MODE_RANGE, '0, '0, 5, 9, 0, 5);          // clipped range empty
    send_item(MODE_RANGE, '0, '0, 4, 4, 100, -100);     // result bounds cross
    send_item(MODE_RAISE, '0, '0, 0, 4, 8, 0);
    send_item(MODE_RAISE, '0, '0, 0, 4, 32'sh7fffffff, 0);
    send_item(MODE_RAISE, '0, '0, 2, 2, 8, 0);          // single index, bounds left as they are
    send_item(MODE_LOWER, '0, '0, 0, 4, 0, 0);
    send_item(MODE_LOWER, '0, '0, 0, 4, 0, 32'sh80000000);
    send_item(MODE_LOWER, '0, '0, 32'sh80000000, 32'sh7fffffff, 0, 6);
    send_item(3'd5, '0, '0, 0, 4, 0, 0);
    send_item(3'd6, '0, '0, 0, 4, 0, 0);
    send_item(3'd7, '0, '0, 0, 4, 0, 0);
    load_elem(MAX_ELEM - 1, 32'sh7fffffff);
    settle();
    write_reg(REG_FROM_ZERO, 0);
    send_item(MODE_RANGE, '0, '0, 1, 5, 0, 0);
    send_item(MODE_RAISE, '0, '0, 0, 5, 8, 0);
    send_item(MODE_LOWER, '0, '0, 1, 5, 0, 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_phase();
    random_phase(0, 1, 40, 0);
    random_phase(1, 37, 100, 0);
    random_phase(0, 64, 80, 1);
    random_phase(1, 120, 100, 0);
    // lower the count without a rebuild: the old tables still cover it
    settle();
    write_reg(REG_COUNT, 80);
    write_reg(2'd2, $urandom);
    write_reg(2'd3, $urandom);
    calm = 1'b0;
    for (int q = 0; q < 40; q++) random_query(80);
    // count saturates at the array size: ranges past it fail, reads stay in built part
    settle();
    calm = 1'b1;
    write_reg(REG_COUNT, 2047);
    send_item(MODE_RANGE, '0, '0, 1100, 1200, 0, 0);
    send_item(MODE_RAISE, '0, '0, 1024, 32'sh7fffffff, 0, 0);
    send_item(MODE_RANGE, '0, '0, 0, 50, -5, 5);
    send_item(MODE_LOWER, '0, '0, 10, 60, 0, 0);
    random_phase(1, 0, 30, 0);      // every query fails
    settle();
    if (sb.pending.size() != 0) sb.report_mismatch("expected results left over");
    if (sb.errors == 0) begin
      $display("element_bounds_propagator regression: pass");
    end else begin
      $display("element_bounds_propagator regression: fail");
    end
    $finish;
  end

  initial begin
    bounds_res_t got;
    int          stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.fail = fail_o;
      got.lo   = new_lo_o;
      got.hi   = new_hi_o;
      got.lt   = lo_tightened_o;
      got.ht   = hi_tightened_o;
      sb.check_result(got);
    end
  end

endmodule

FILE: element_bounds_propagator.f
rtl/core/ebp_pkg.sv
rtl/core/ebp_front.sv
rtl/core/ebp_back.sv
rtl/core/element_bounds_propagator.sv
rtl/core/ebp_checker.sv
test/element_bounds_propagator_tb.sv
